// ----- rtl/vdbc_pkg.sv -----
package vdbc_pkg;

  // Fixed tick constants
  localparam int AckTicks     = 8;
  localparam int StartupTicks = 40;
  localparam int BlinkCount   = 2;
  localparam int GainMid      = 10;

  // Start-up blink half period in ticks, never below one
  localparam int BlinkDivRaw = StartupTicks / (2 * BlinkCount);
  localparam int BlinkDiv    = (BlinkDivRaw == 0) ? 1 : BlinkDivRaw;

  localparam int AckW    = $clog2(AckTicks + 1);
  localparam int StartW  = $clog2(StartupTicks + 2);
  localparam int BlinkW  = $clog2(BlinkDiv + 1);

  // speed (s8) times gain (u7) fits in 15 bits signed; magnitude below 2^14
  localparam int ProdW  = 16;
  localparam int MagW   = 14;
  localparam int DriveW = 16;

  // Reciprocal for the divide by GainMid: exact floor for any MagW-bit value
  localparam int ScaleShift = MagW + $clog2(GainMid) + 1;
  localparam int RecipW     = ScaleShift + 1;
  localparam logic [RecipW-1:0] ScaleRecip =
      RecipW'(((64'd1 << ScaleShift) + 64'(GainMid) - 64'd1) / 64'(GainMid));

  // Request codes
  localparam logic [1:0] TrimNone  = 2'd0;
  localparam logic [1:0] TrimReset = 2'd1;
  localparam logic [1:0] TrimRight = 2'd2;
  localparam logic [1:0] TrimLeft  = 2'd3;

  localparam logic [1:0] GainNone  = 2'd0;
  localparam logic [1:0] GainReset = 2'd1;
  localparam logic [1:0] GainUp    = 2'd2;
  localparam logic [1:0] GainDown  = 2'd3;

  // Winker codes
  localparam logic [2:0] TurnOff        = 3'd0;
  localparam logic [2:0] TurnBothOn     = 3'd1;
  localparam logic [2:0] TurnRightOn    = 3'd2;
  localparam logic [2:0] TurnLeftOn     = 3'd3;
  localparam logic [2:0] TurnBothBlink  = 3'd4;
  localparam logic [2:0] TurnRightBlink = 3'd5;
  localparam logic [2:0] TurnLeftBlink  = 3'd6;

  // Buzzer codes
  localparam logic [1:0] BuzzOff      = 2'd0;
  localparam logic [1:0] BuzzOn       = 2'd1;
  localparam logic [1:0] BuzzInterval = 2'd2;

  // Config register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgNeutralReset = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNeutralLow   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNeutralHigh  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgGainReset    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgGainLow      = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgGainHigh     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgBodyRemote   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSendPeriod   = 3'd7;
  localparam int CfgDataW = 16;

  // Config reset values
  localparam logic signed [7:0] NeutralResetDef = 8'sd0;
  localparam logic signed [7:0] NeutralLowDef   = -8'sd20;
  localparam logic signed [7:0] NeutralHighDef  = 8'sd20;
  localparam logic [6:0]        GainResetDef    = 7'd10;
  localparam logic [6:0]        GainLowDef      = 7'd1;
  localparam logic [6:0]        GainHighDef     = 7'd20;
  localparam logic [15:0]       SendPeriodDef   = 16'd10;

  typedef struct packed {
    logic signed [7:0] neutral_reset_value;
    logic signed [7:0] neutral_lowest;
    logic signed [7:0] neutral_highest;
    logic [6:0]        gain_reset_value;
    logic [6:0]        gain_lowest;
    logic [6:0]        gain_highest;
    logic              body_remote;
    logic [15:0]       send_period_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        trim_request;
    logic [1:0]        gain_request;
    logic signed [7:0] angle_cmd;
    logic signed [7:0] speed_cmd;
    logic              brake_cmd;
    logic              headlamp_switch;
    logic              foglamp_switch;
    logic              hazard_switch;
    logic              right_turn_switch;
    logic              left_turn_switch;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0]        steer_out;
    logic signed [DriveW-1:0] drive_out;
    logic                     brake_out;
    logic                     head_lamp;
    logic                     fog_lamp;
    logic                     stop_lamp;
    logic                     reverse_lamp;
    logic [2:0]               turn_code;
    logic [1:0]               buzzer_code;
    logic                     send_strobe;
  } out_item_t;

  // Between the tick stage and the scale stage: drive_out still empty
  typedef struct packed {
    out_item_t               res;
    logic signed [ProdW-1:0] prod;
  } mid_t;

endpackage

// ----- rtl/vdbc_tick.sv -----
module vdbc_tick (
  input  logic               clk,
  input  logic               rst,
  input  vdbc_pkg::cfg_t     cfg,
  input  vdbc_pkg::in_item_t item,
  input  logic               adv,
  output vdbc_pkg::mid_t     mid
);

  logic signed [7:0]              neutral, neutral_next;
  logic [6:0]                     gain, gain_next;
  logic [vdbc_pkg::AckW-1:0]      ack_both, ack_both_next;
  logic [vdbc_pkg::AckW-1:0]      ack_right, ack_right_next;
  logic [vdbc_pkg::AckW-1:0]      ack_left, ack_left_next;
  logic [vdbc_pkg::AckW-1:0]      both_ld, right_ld, left_ld;
  logic [vdbc_pkg::AckW-1:0]      both_dec, right_dec, left_dec;
  logic [vdbc_pkg::StartW-1:0]    startup_cnt, startup_cnt_next;
  logic [vdbc_pkg::BlinkW-1:0]    blink_sub, blink_sub_next;
  logic                           blink_odd, blink_odd_next;
  logic [4:0]                     latches, latches_next;
  logic [4:0]                     prev_sw, prev_sw_next;
  logic [15:0]                    send_cd, send_cd_next;
  logic [15:0]                    cd_base;
  logic [4:0]                     sw, latch_new;
  logic                           in_startup, startup_on, neg_speed;
  logic [2:0]                     turn;

  always_comb begin
    neutral_next = neutral;
    case (item.trim_request)
      vdbc_pkg::TrimReset: neutral_next = cfg.neutral_reset_value;
      vdbc_pkg::TrimRight: begin
        if (neutral > cfg.neutral_lowest) neutral_next = neutral - 8'sd1;
      end
      vdbc_pkg::TrimLeft: begin
        if (neutral < cfg.neutral_highest) neutral_next = neutral + 8'sd1;
      end
      default: neutral_next = neutral;
    endcase

    gain_next = gain;
    case (item.gain_request)
      vdbc_pkg::GainReset: gain_next = cfg.gain_reset_value;
      vdbc_pkg::GainUp: begin
        if (gain < cfg.gain_highest) gain_next = gain + 7'd1;
      end
      vdbc_pkg::GainDown: begin
        if (gain > cfg.gain_lowest) gain_next = gain - 7'd1;
      end
      default: gain_next = gain;
    endcase
  end

  // Acknowledge loads land before this tick's body logic
  always_comb begin
    both_ld  = (item.trim_request == vdbc_pkg::TrimReset ||
                item.gain_request == vdbc_pkg::GainReset) ?
               vdbc_pkg::AckW'(vdbc_pkg::AckTicks) : ack_both;
    right_ld = (item.trim_request == vdbc_pkg::TrimRight ||
                item.gain_request == vdbc_pkg::GainUp) ?
               vdbc_pkg::AckW'(vdbc_pkg::AckTicks) : ack_right;
    left_ld  = (item.trim_request == vdbc_pkg::TrimLeft ||
                item.gain_request == vdbc_pkg::GainDown) ?
               vdbc_pkg::AckW'(vdbc_pkg::AckTicks) : ack_left;
    both_dec  = (both_ld  != '0) ? both_ld  - vdbc_pkg::AckW'(1) : both_ld;
    right_dec = (right_ld != '0) ? right_ld - vdbc_pkg::AckW'(1) : right_ld;
    left_dec  = (left_ld  != '0) ? left_ld  - vdbc_pkg::AckW'(1) : left_ld;
  end

  always_comb begin
    sw         = {item.left_turn_switch, item.right_turn_switch, item.hazard_switch,
                  item.foglamp_switch, item.headlamp_switch};
    latch_new  = latches ^ (sw & ~prev_sw);
    neg_speed  = item.speed_cmd[7];
    in_startup = (startup_cnt <= vdbc_pkg::StartW'(vdbc_pkg::StartupTicks));
    startup_on = !blink_odd && (startup_cnt != vdbc_pkg::StartW'(vdbc_pkg::StartupTicks));

    // last running counter in the order both, right, left sets the code
    if (left_ld != '0) begin
      turn = (left_dec != '0) ? vdbc_pkg::TurnLeftOn : vdbc_pkg::TurnOff;
    end else if (right_ld != '0) begin
      turn = (right_dec != '0) ? vdbc_pkg::TurnRightOn : vdbc_pkg::TurnOff;
    end else if (both_ld != '0) begin
      turn = (both_dec != '0) ? vdbc_pkg::TurnBothOn : vdbc_pkg::TurnOff;
    end else if (latch_new[2] || (latch_new[3] && latch_new[4])) begin
      turn = vdbc_pkg::TurnBothBlink;
    end else if (latch_new[3]) begin
      turn = vdbc_pkg::TurnRightBlink;
    end else if (latch_new[4]) begin
      turn = vdbc_pkg::TurnLeftBlink;
    end else begin
      turn = vdbc_pkg::TurnOff;
    end
  end

  always_comb begin
    ack_both_next    = both_dec;
    ack_right_next   = right_dec;
    ack_left_next    = left_dec;
    latches_next     = latch_new;
    prev_sw_next     = sw;
    startup_cnt_next = startup_cnt;
    blink_sub_next   = blink_sub;
    blink_odd_next   = blink_odd;
    cd_base          = send_cd;

    mid.res.steer_out   = 9'(item.angle_cmd) + 9'(neutral_next);
    mid.res.drive_out   = '0;
    mid.res.brake_out   = item.brake_cmd;
    mid.res.head_lamp   = latch_new[0];
    mid.res.fog_lamp    = latch_new[1];
    mid.res.stop_lamp   = item.brake_cmd;
    mid.res.reverse_lamp = neg_speed;
    mid.res.turn_code   = turn;
    mid.res.buzzer_code = neg_speed ? vdbc_pkg::BuzzInterval : vdbc_pkg::BuzzOff;

    if (in_startup) begin
      ack_both_next    = both_ld;
      ack_right_next   = right_ld;
      ack_left_next    = left_ld;
      latches_next     = latches;
      prev_sw_next     = prev_sw;
      startup_cnt_next = startup_cnt + vdbc_pkg::StartW'(1);
      if (blink_sub == vdbc_pkg::BlinkW'(vdbc_pkg::BlinkDiv - 1)) begin
        blink_sub_next = '0;
        blink_odd_next = !blink_odd;
      end else begin
        blink_sub_next = blink_sub + vdbc_pkg::BlinkW'(1);
      end
      cd_base = '0;
      mid.res.head_lamp    = startup_on;
      mid.res.fog_lamp     = startup_on;
      mid.res.stop_lamp    = startup_on;
      mid.res.reverse_lamp = startup_on;
      mid.res.turn_code    = startup_on ? vdbc_pkg::TurnBothOn : vdbc_pkg::TurnOff;
      mid.res.buzzer_code  = startup_on ? vdbc_pkg::BuzzOn : vdbc_pkg::BuzzOff;
    end

    mid.res.send_strobe = cfg.body_remote && (cd_base == '0);
    if (!cfg.body_remote) begin
      send_cd_next = cd_base;
    end else if (cd_base == '0) begin
      send_cd_next = cfg.send_period_ticks;
    end else begin
      send_cd_next = cd_base - 16'd1;
    end

    mid.prod = vdbc_pkg::ProdW'(item.speed_cmd) *
               vdbc_pkg::ProdW'($signed({1'b0, gain_next}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neutral     <= vdbc_pkg::NeutralResetDef;
      gain        <= vdbc_pkg::GainResetDef;
      ack_both    <= '0;
      ack_right   <= '0;
      ack_left    <= '0;
      startup_cnt <= '0;
      blink_sub   <= '0;
      blink_odd   <= 1'b0;
      latches     <= '0;
      prev_sw     <= '0;
      send_cd     <= '0;
    end else if (adv) begin
      neutral     <= neutral_next;
      gain        <= gain_next;
      ack_both    <= ack_both_next;
      ack_right   <= ack_right_next;
      ack_left    <= ack_left_next;
      startup_cnt <= startup_cnt_next;
      blink_sub   <= blink_sub_next;
      blink_odd   <= blink_odd_next;
      latches     <= latches_next;
      prev_sw     <= prev_sw_next;
      send_cd     <= send_cd_next;
    end
  end

endmodule

// ----- rtl/vdbc_scale.sv -----
module vdbc_scale (
  input  logic signed [vdbc_pkg::ProdW-1:0]  prod,
  output logic signed [vdbc_pkg::DriveW-1:0] drive
);

  localparam int FullW = vdbc_pkg::MagW + vdbc_pkg::RecipW;

  logic [vdbc_pkg::ProdW-1:0] abs_prod;
  logic [vdbc_pkg::MagW-1:0]  mag;
  logic [FullW-1:0]           full;
  logic [vdbc_pkg::MagW-1:0]  quo;

  // divide by the mid gain through a reciprocal; sign handled here by magnitude and negation
  always_comb begin
    abs_prod = prod[vdbc_pkg::ProdW-1] ? (vdbc_pkg::ProdW'(0) - prod) : prod;
    mag      = abs_prod[vdbc_pkg::MagW-1:0];
    full     = FullW'(mag) * FullW'(vdbc_pkg::ScaleRecip);
    quo      = vdbc_pkg::MagW'(full >> vdbc_pkg::ScaleShift);
    drive    = prod[vdbc_pkg::ProdW-1] ?
               (vdbc_pkg::DriveW'(0) - vdbc_pkg::DriveW'(quo)) : vdbc_pkg::DriveW'(quo);
  end

endmodule

// ----- rtl/vehicle_drive_and_body_controller_core.sv -----
// Channel   | Direction | Handshake                  | Beat contents
// ----------+-----------+----------------------------+-------------------------------
// item      | in        | item_valid / item_ready    | one control tick (in_item_t)
// result    | out       | result_valid / result_ready| tick outputs (out_item_t)
// cfg       | in        | cfg_valid / cfg_ready      | register index + write data
//
// One beat per cycle sustained while the result is not stalled; an accepted beat
// enters the input register, which feeds one combinational pass (state update,
// steer add, speed x gain product, divide by mid gain) into the result register.
// Synchronous reset clears both valids and returns tick state and config registers to defaults.
// A stalled result holds the input register in place; it still takes a beat
// while the result drains in the same cycle. cfg_ready is always high.
module vehicle_drive_and_body_controller_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  vdbc_pkg::in_item_t                item,
  output logic                              result_valid,
  input  logic                              result_ready,
  output vdbc_pkg::out_item_t               result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vdbc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [vdbc_pkg::CfgDataW-1:0]     cfg_data
);

  vdbc_pkg::cfg_t      cfg;
  vdbc_pkg::in_item_t  s0_item;
  logic                s0_valid;
  vdbc_pkg::mid_t      tick_mid;
  vdbc_pkg::out_item_t res_next;
  logic signed [vdbc_pkg::DriveW-1:0] drive;
  logic                out_free, adv;

  // Ready chain: the input register takes a beat when empty or when it drains
  assign out_free   = !result_valid || result_ready;
  assign item_ready = !s0_valid || out_free;
  assign adv        = s0_valid && out_free;
  assign cfg_ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.neutral_reset_value <= vdbc_pkg::NeutralResetDef;
      cfg.neutral_lowest      <= vdbc_pkg::NeutralLowDef;
      cfg.neutral_highest     <= vdbc_pkg::NeutralHighDef;
      cfg.gain_reset_value    <= vdbc_pkg::GainResetDef;
      cfg.gain_lowest         <= vdbc_pkg::GainLowDef;
      cfg.gain_highest        <= vdbc_pkg::GainHighDef;
      cfg.body_remote         <= 1'b0;
      cfg.send_period_ticks   <= vdbc_pkg::SendPeriodDef;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        vdbc_pkg::CfgNeutralReset: cfg.neutral_reset_value <= cfg_data[7:0];
        vdbc_pkg::CfgNeutralLow:   cfg.neutral_lowest      <= cfg_data[7:0];
        vdbc_pkg::CfgNeutralHigh:  cfg.neutral_highest     <= cfg_data[7:0];
        vdbc_pkg::CfgGainReset:    cfg.gain_reset_value    <= cfg_data[6:0];
        vdbc_pkg::CfgGainLow:      cfg.gain_lowest         <= cfg_data[6:0];
        vdbc_pkg::CfgGainHigh:     cfg.gain_highest        <= cfg_data[6:0];
        vdbc_pkg::CfgBodyRemote:   cfg.body_remote         <= cfg_data[0];
        vdbc_pkg::CfgSendPeriod:   cfg.send_period_ticks   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (item_ready) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s0_item <= item;
    end
  end

  // Tick logic: state advances exactly once per beat moving into the result
  vdbc_tick u_tick (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (s0_item),
    .adv  (adv),
    .mid  (tick_mid)
  );

  // Divide by mid gain in the same pass
  vdbc_scale u_scale (
    .prod  (tick_mid.prod),
    .drive (drive)
  );

  always_comb begin
    res_next           = tick_mid.res;
    res_next.drive_out = drive;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

  // Reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !s0_valid && !result_valid)
    else $error("pipeline not empty after reset");

  // A stalled result beat stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result beat changed while stalled");

  // Interval buzzer only comes with the back lamp
  a_buzz_reverse: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.buzzer_code == vdbc_pkg::BuzzInterval |-> result.reverse_lamp)
    else $error("interval buzzer without back lamp");

endmodule
